FILE: sv/dqpb_pkg.sv
// Shared types and constants for the DNS query packet builder.
package dqpb_pkg;

	localparam int MAX_LABEL = 32;
	localparam int CNT_W     = $clog2(MAX_LABEL + 1);
	localparam int LBL_IDX_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
	localparam int IDX_W     = (CNT_W > 4) ? CNT_W : 4;
	localparam int CFG_IDX_W = 8;

	localparam logic [7:0]       SEP_CHAR = 8'h2e;
	localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(11);
	localparam logic [IDX_W-1:0] TRL_LAST = IDX_W'(4);

	localparam logic [15:0] QUERY_ID_RST    = 16'h08bb;
	localparam logic [15:0] HEADER_FLAGS_RST = 16'h0100;
	localparam logic [15:0] QUERY_TYPE_RST  = 16'h0001;
	localparam logic [15:0] QUERY_CLASS_RST = 16'h0001;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUERY_ID     = 8'd0,
		REG_HEADER_FLAGS = 8'd1,
		REG_QUERY_TYPE   = 8'd2,
		REG_QUERY_CLASS  = 8'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_LEN,
		ST_DATA,
		ST_TRL
	} state_t;

	typedef enum logic [2:0] {
		SRC_HDR,
		SRC_LEN,
		SRC_DATA,
		SRC_TRL
	} src_t;

	typedef struct packed {
		logic accept;
		logic load_out;
		src_t src;
		logic run_last;
		logic pkt_end;
		logic idx_clr;
		logic idx_inc;
		logic clr_label;
		logic clr_sep;
		logic set_hdr;
		logic clr_hdr;
	} cmd_t;

	typedef struct packed {
		logic             in_sep;
		logic             in_last;
		logic             sep;
		logic             last;
		logic             hdr_sent;
		logic             out_free;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] idx;
	} sts_t;

endpackage

FILE: sv/dqpb_ctrl.sv
// Controller state machine sequencing header, label flushes and trailer.
module dqpb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  dqpb_pkg::sts_t sts,
	output dqpb_pkg::cmd_t cmd
);
	import dqpb_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_ext;

	assign cnt_ext = IDX_W'(sts.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.src  = SRC_HDR;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept  = 1'b1;
					cmd.idx_clr = 1'b1;
					if (!sts.hdr_sent) begin
						state_d = ST_HDR;
					end else if (sts.in_sep || sts.in_last) begin
						state_d = ST_LEN;
					end
				end
			end
			ST_HDR: begin
				cmd.src = SRC_HDR;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (sts.idx == HDR_LAST) begin
						cmd.set_hdr  = 1'b1;
						cmd.idx_clr  = 1'b1;
						cmd.run_last = !sts.sep && !sts.last;
						state_d = (sts.sep || sts.last) ? ST_LEN : ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_LEN, ST_DATA: begin
				cmd.src = (state_q == ST_LEN) ? SRC_LEN : SRC_DATA;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (state_q == ST_LEN && sts.count != '0) begin
						cmd.idx_clr = 1'b1;
						state_d = ST_DATA;
					end else if (state_q == ST_DATA && sts.idx != cnt_ext - IDX_W'(1)) begin
						cmd.idx_inc = 1'b1;
					end else begin
						// label done: second (empty) flush on a trailing dot
						cmd.clr_label = 1'b1;
						cmd.idx_clr   = 1'b1;
						if (sts.sep) begin
							cmd.clr_sep = 1'b1;
							if (sts.last) begin
								state_d = ST_LEN;
							end else begin
								cmd.run_last = 1'b1;
								state_d = ST_IDLE;
							end
						end else begin
							state_d = ST_TRL;
						end
					end
				end
			end
			ST_TRL: begin
				cmd.src = SRC_TRL;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (sts.idx == TRL_LAST) begin
						cmd.run_last  = 1'b1;
						cmd.pkt_end   = 1'b1;
						cmd.clr_hdr   = 1'b1;
						cmd.clr_label = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: sv/dqpb_dpath.sv
// Datapath: config registers, label buffer, byte counter and output register.
module dqpb_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,
	output logic                            m_tlast,
	output logic [1:0]                      m_tuser,
	input  logic                            cfg_valid,
	input  logic [dqpb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                     cfg_data,
	input  dqpb_pkg::cmd_t                  cmd,
	output dqpb_pkg::sts_t                  sts
);
	import dqpb_pkg::*;

	logic [15:0] query_id_q, header_flags_q, query_type_q, query_class_q;
	logic [7:0]  label_store [MAX_LABEL];
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic        ovf_q, hdr_sent_q, sep_q, last_q;
	logic        in_sep;
	logic [7:0]  byte_d, hdr_byte, trl_byte;
	logic        ovf_d;
	logic        out_valid_q, out_end_q, out_run_q, out_ovf_q;
	logic [7:0]  out_byte_q;

	assign in_sep = (s_tdata == SEP_CHAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_id_q     <= QUERY_ID_RST;
			header_flags_q <= HEADER_FLAGS_RST;
			query_type_q   <= QUERY_TYPE_RST;
			query_class_q  <= QUERY_CLASS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_QUERY_ID:     query_id_q     <= cfg_data;
				REG_HEADER_FLAGS: header_flags_q <= cfg_data;
				REG_QUERY_TYPE:   query_type_q   <= cfg_data;
				REG_QUERY_CLASS:  query_class_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// label buffer, written on accept of a plain byte with room left
	always_ff @(posedge clk) begin
		if (cmd.accept && !in_sep && count_q < CNT_W'(MAX_LABEL)) begin
			label_store[count_q[LBL_IDX_W-1:0]] <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			hdr_sent_q <= 1'b0;
			sep_q      <= 1'b0;
			last_q     <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (cmd.accept) begin
				sep_q  <= in_sep;
				last_q <= s_tlast;
				if (!in_sep) begin
					if (count_q < CNT_W'(MAX_LABEL)) begin
						count_q <= count_q + CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (cmd.clr_label) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.clr_sep) begin
				sep_q <= 1'b0;
			end
			if (cmd.set_hdr) begin
				hdr_sent_q <= 1'b1;
			end else if (cmd.clr_hdr) begin
				hdr_sent_q <= 1'b0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_comb begin
		unique case (idx_q)
			IDX_W'(0): hdr_byte = query_id_q[15:8];
			IDX_W'(1): hdr_byte = query_id_q[7:0];
			IDX_W'(2): hdr_byte = header_flags_q[15:8];
			IDX_W'(3): hdr_byte = header_flags_q[7:0];
			IDX_W'(5): hdr_byte = 8'd1;
			default:   hdr_byte = 8'd0;
		endcase
		unique case (idx_q)
			IDX_W'(1): trl_byte = query_type_q[15:8];
			IDX_W'(2): trl_byte = query_type_q[7:0];
			IDX_W'(3): trl_byte = query_class_q[15:8];
			IDX_W'(4): trl_byte = query_class_q[7:0];
			default:   trl_byte = 8'd0;
		endcase
		ovf_d = 1'b0;
		unique case (cmd.src)
			SRC_HDR: byte_d = hdr_byte;
			SRC_LEN: begin
				byte_d = 8'(count_q);
				ovf_d  = ovf_q;
			end
			SRC_DATA: begin
				// buffer byte is read straight into the output register
				byte_d = 8'd0;
				ovf_d  = ovf_q;
			end
			SRC_TRL: byte_d = trl_byte;
			default: byte_d = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_byte_q <= (cmd.src == SRC_DATA) ? label_store[idx_q[LBL_IDX_W-1:0]] : byte_d;
			out_end_q  <= cmd.pkt_end;
			out_run_q  <= cmd.run_last;
			out_ovf_q  <= ovf_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = {out_ovf_q, out_run_q};

	assign sts.in_sep   = in_sep;
	assign sts.in_last  = s_tlast;
	assign sts.sep      = sep_q;
	assign sts.last     = last_q;
	assign sts.hdr_sent = hdr_sent_q;
	assign sts.out_free = !out_valid_q || m_tready;
	assign sts.count    = count_q;
	assign sts.idx      = idx_q;

endmodule

FILE: sv/dns_query_packet_builder_unit.sv
// Top level of the DNS query packet builder: controller plus datapath.
//
//   channel  | direction | handshake               | payload
//   s_*      | in        | s_tvalid / s_tready     | s_tdata name_char, s_tlast name_last
//   m_*      | out       | m_tvalid / m_tready     | m_tdata out_byte, m_tlast packet_end,
//            |           |                         | m_tuser run_last, label_overflow
//   cfg_*    | in        | cfg_valid / cfg_ready   | cfg_index register, cfg_data value
//
// An item is taken only while the sequencer is idle; each result byte then passes
// through the single output register: 12 header bytes, 1 + length per label and
// 5 trailer bytes.
// The output register drains while the next item is taken.
// Reset returns the sequencer to idle and the registers to their defaults.
// A stall on m_tready holds the sequencer in place.
module dns_query_packet_builder_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] name_char
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_byte
	output logic                           m_tlast,
	output logic [1:0]                     m_tuser,   // [0] run_last, [1] label_overflow
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dqpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import dqpb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	dqpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dqpb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: test/tb.sv
// Testbench for the DNS query packet builder: directed table plus random host names.
`timescale 1ns / 100ps

module tb;
	import dqpb_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 11;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int PHASES          = 8;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 5000;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE  = {CFG_IDX_W{1'b1}};

	typedef struct packed {
		logic [7:0] data;
		logic       pkt_end;
		logic       run_last;
		logic       ovf;
	} wire_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} name_item_t;

	typedef struct {
		logic [7:0]       ch;
		logic             lst;
		int               n_typed;
		logic [0:23][7:0] typed;
	} dir_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = 8'h00;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;
	logic [1:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data  = 16'h0000;

	// Expected message bytes, oldest first
	wire_byte_t wire_bytes_q[$];
	wire_byte_t step_bytes_q[$];
	name_item_t name_q[$];

	// Predictor state
	logic [7:0]  lbl_mem [MAX_LABEL];
	int          lbl_len;
	logic        hdr_out;
	logic        lbl_trunc;
	logic [15:0] id_reg;
	logic [15:0] flags_reg;
	logic [15:0] qtype_reg;
	logic [15:0] qclass_reg;

	int err_count    = 0;
	int stall_cycles = 0;
	bit hold_out     = 1'b0;
	bit no_idle      = 1'b0;

	// Leading, double and trailing dots, byte extremes; the first two rows are typed in
	dir_row_t dir_tab [17] = '{
		'{SEP_CHAR, 1'b1, 19, {8'h08, 8'hbb, 8'h01, 8'h00, 8'h00, 8'h01, {6{8'h00}},
			8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, {5{8'h00}}}},
		'{8'hff, 1'b1, 19, {8'h08, 8'hbb, 8'h01, 8'h00, 8'h00, 8'h01, {6{8'h00}},
			8'h01, 8'hff, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, {5{8'h00}}}},
		'{8'h00, 1'b0, 0, '0},
		'{SEP_CHAR, 1'b0, 0, '0},
		'{SEP_CHAR, 1'b0, 0, '0},
		'{8'h80, 1'b0, 0, '0},
		'{8'h2d, 1'b0, 0, '0},
		'{8'h2f, 1'b0, 0, '0},
		'{8'h7f, 1'b0, 0, '0},
		'{SEP_CHAR, 1'b0, 0, '0},
		'{8'h01, 1'b1, 0, '0},
		'{SEP_CHAR, 1'b0, 0, '0},
		'{8'h41, 1'b0, 0, '0},
		'{SEP_CHAR, 1'b1, 0, '0},
		'{8'h00, 1'b1, 0, '0},
		'{SEP_CHAR, 1'b0, 0, '0},
		'{SEP_CHAR, 1'b1, 0, '0}
	};

	dns_query_packet_builder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("mismatch on %s: expected %0h, got %0h", what, want, got);
		err_count++;
	endtask

	task automatic emit_byte(input logic [7:0] d, input logic e, input logic o);
		step_bytes_q.push_back('{d, e, 1'b0, o});
	endtask

	// Length byte, then the buffered bytes; clear the label
	task automatic emit_label();
		emit_byte(8'(lbl_len), 1'b0, lbl_trunc);
		for (int k = 0; k < lbl_len; k++)
			emit_byte(lbl_mem[k], 1'b0, lbl_trunc);
		lbl_len   = 0;
		lbl_trunc = 1'b0;
	endtask

	task automatic build_query_bytes(input logic [7:0] ch, input logic lst);
		wire_byte_t tail;
		step_bytes_q.delete();
		if (!hdr_out) begin
			emit_byte(id_reg[15:8], 1'b0, 1'b0);
			emit_byte(id_reg[7:0], 1'b0, 1'b0);
			emit_byte(flags_reg[15:8], 1'b0, 1'b0);
			emit_byte(flags_reg[7:0], 1'b0, 1'b0);
			emit_byte(8'h00, 1'b0, 1'b0);
			emit_byte(8'h01, 1'b0, 1'b0);
			repeat (6) emit_byte(8'h00, 1'b0, 1'b0);
			hdr_out = 1'b1;
		end
		if (ch == SEP_CHAR) begin
			emit_label();
		end else if (lbl_len < MAX_LABEL) begin
			lbl_mem[lbl_len] = ch;
			lbl_len++;
		end else begin
			lbl_trunc = 1'b1;
		end
		if (lst) begin
			emit_label();
			emit_byte(8'h00, 1'b0, 1'b0);
			emit_byte(qtype_reg[15:8], 1'b0, 1'b0);
			emit_byte(qtype_reg[7:0], 1'b0, 1'b0);
			emit_byte(qclass_reg[15:8], 1'b0, 1'b0);
			emit_byte(qclass_reg[7:0], 1'b1, 1'b0);
			hdr_out = 1'b0;
		end
		if (step_bytes_q.size() > 0) begin
			tail = step_bytes_q.pop_back();
			tail.run_last = 1'b1;
			step_bytes_q.push_back(tail);
		end
	endtask

	task automatic send_name_byte(input logic [7:0] ch, input logic lst, input int n_typed,
			input logic [0:23][7:0] typed);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		build_query_bytes(ch, lst);
		if (n_typed > 0) begin
			for (int k = 0; k < n_typed; k++)
				wire_bytes_q.push_back('{typed[k], k == n_typed - 1, k == n_typed - 1, 1'b0});
		end else begin
			foreach (step_bytes_q[k]) wire_bytes_q.push_back(step_bytes_q[k]);
		end
	endtask

	// Drop valid, wait for every expected byte, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (wire_bytes_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_QUERY_ID:     id_reg     = val;
			REG_HEADER_FLAGS: flags_reg  = val;
			REG_QUERY_TYPE:   qtype_reg  = val;
			REG_QUERY_CLASS:  qclass_reg = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input int ph);
		logic [15:0] v [4];
		for (int k = 0; k < 4; k++) begin
			if (ph == 0)
				v[k] = 16'h0000;
			else if (ph == 1)
				v[k] = 16'hffff;
			else
				v[k] = 16'($urandom);
		end
		cfg_write(CFG_IDX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)), 16'($urandom));
		cfg_write(REG_QUERY_ID, v[0]);
		cfg_write(REG_HEADER_FLAGS, v[1]);
		cfg_write(REG_QUERY_TYPE, v[2]);
		cfg_write(REG_QUERY_CLASS, v[3]);
		cfg_write(REG_LAST_SPARE, ~v[0]);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed names; some with extra dots, some raw noise
	task automatic gen_name();
		int         kind;
		int         nlab;
		int         len;
		int         r;
		logic [7:0] b;
		name_item_t part[$];
		kind = $urandom_range(0, 9);
		if (kind >= 8) begin
			repeat ($urandom_range(1, 12)) begin
				b = ($urandom_range(0, 3) == 0) ? SEP_CHAR : 8'($urandom);
				name_q.push_back('{b, $urandom_range(0, 5) == 0});
			end
		end else begin
			if (kind == 7 && $urandom_range(0, 1) == 1)
				part.push_back('{SEP_CHAR, 1'b0});
			nlab = $urandom_range(1, 4);
			for (int i = 0; i < nlab; i++) begin
				if (i > 0)
					part.push_back('{SEP_CHAR, 1'b0});
				r = $urandom_range(0, 15);
				if (r == 0)
					len = 0;
				else if (r == 1)
					len = $urandom_range(MAX_LABEL - 2, MAX_LABEL + 2);
				else if (r == 2)
					len = $urandom_range(MAX_LABEL + 3, MAX_LABEL + 13);
				else
					len = $urandom_range(1, 8);
				repeat (len) begin
					do b = 8'($urandom); while (b == SEP_CHAR);
					part.push_back('{b, 1'b0});
				end
			end
			if (kind == 7 && $urandom_range(0, 1) == 1)
				part.push_back('{SEP_CHAR, 1'b0});
			if (part.size() == 0)
				part.push_back('{SEP_CHAR, 1'b0});
			part[part.size() - 1].lst = 1'b1;
			foreach (part[k]) name_q.push_back(part[k]);
		end
	endtask

	// Receiver: random gaps per byte, one long hold on request
	initial begin
		int gap;
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 3);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_out
		wire_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (wire_bytes_q.size() == 0) begin
				report_mismatch("unexpected byte", 0, m_tdata);
			end else begin
				want = wire_bytes_q.pop_front();
				if (m_tdata !== want.data)
					report_mismatch("out_byte", want.data, m_tdata);
				if (m_tlast !== want.pkt_end)
					report_mismatch("packet_end", want.pkt_end, m_tlast);
				if (m_tuser[0] !== want.run_last)
					report_mismatch("run_last", want.run_last, m_tuser[0]);
				if (m_tuser[1] !== want.ovf)
					report_mismatch("label_overflow", want.ovf, m_tuser[1]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		lbl_len    = 0;
		hdr_out    = 1'b0;
		lbl_trunc  = 1'b0;
		id_reg     = QUERY_ID_RST;
		flags_reg  = HEADER_FLAGS_RST;
		qtype_reg  = QUERY_TYPE_RST;
		qclass_reg = QUERY_CLASS_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_name_byte(dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].n_typed, dir_tab[i].typed);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			load_settings(ph);
			name_q.delete();
			while (name_q.size() < ITEMS_PER_PHASE) gen_name();
			// Close the phase on a complete name so the next writes find the block empty
			name_q[name_q.size() - 1].lst = 1'b1;
			no_idle = (ph == 3 || ph == 6);
			// Stall the output long enough for the input side to back up
			if (ph == 2)
				hold_out = 1'b1;
			foreach (name_q[i])
				send_name_byte(name_q[i].ch, name_q[i].lst, 0, '0);
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
sv/dqpb_pkg.sv
sv/dqpb_ctrl.sv
sv/dqpb_dpath.sv
sv/dns_query_packet_builder_unit.sv
test/tb.sv
